// ===== sv/exr_pkg.sv =====
// Package with shared types, constants and the CORDIC arctangent table.
`default_nettype none
package exr_pkg;
	localparam int ANG_W   = 16;
	localparam int VEC_W   = 18;
	localparam int TH_W    = 34;
	localparam int CS_W    = 34;
	localparam int TRIG_W  = 18;
	localparam int WIDE_W  = 24;
	localparam int STEPS   = 24;
	localparam int STEPS_PER_STAGE = 4;
	localparam int CSTAGES = STEPS / STEPS_PER_STAGE;
	localparam logic signed [CS_W-1:0] CORDIC_K = 34'sh026DD3B6A;
	localparam logic signed [TH_W-1:0] QUARTER = 34'sh040000000;
	localparam logic signed [TH_W-1:0] HALF = 34'sh080000000;
	localparam logic signed [WIDE_W-1:0] OUT_MAX = 24'sd131071;
	localparam logic signed [WIDE_W-1:0] OUT_MIN = -24'sd131072;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
	} trig_t;

	function automatic logic signed [TH_W-1:0] atan_entry(input logic [4:0] i);
		logic signed [TH_W-1:0] r;
		case (i)
			5'd0: r = 34'sh020000000;
			5'd1: r = 34'sh012E4051E;
			5'd2: r = 34'sh009FB385B;
			5'd3: r = 34'sh0051111D4;
			5'd4: r = 34'sh0028B0D43;
			5'd5: r = 34'sh00145D7E1;
			5'd6: r = 34'sh000A2F61E;
			5'd7: r = 34'sh000517C55;
			5'd8: r = 34'sh00028BE53;
			5'd9: r = 34'sh000145F2F;
			5'd10: r = 34'sh0000A2F98;
			5'd11: r = 34'sh0000517CC;
			5'd12: r = 34'sh000028BE6;
			5'd13: r = 34'sh0000145F3;
			5'd14: r = 34'sh00000A2FA;
			5'd15: r = 34'sh00000517D;
			5'd16: r = 34'sh0000028BE;
			5'd17: r = 34'sh00000145F;
			5'd18: r = 34'sh000000A30;
			5'd19: r = 34'sh000000518;
			5'd20: r = 34'sh00000028C;
			5'd21: r = 34'sh000000146;
			5'd22: r = 34'sh0000000A3;
			5'd23: r = 34'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/exr_sincos.sv =====
// Pipelined CORDIC sine and cosine of one binary angle, four steps per stage.
`default_nettype none
module exr_sincos (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [exr_pkg::ANG_W-1:0] angle,
	output exr_pkg::trig_t                      trig
);
	import exr_pkg::*;

	logic signed [TH_W-1:0] th_q [CSTAGES+1];
	logic signed [CS_W-1:0] x_q [CSTAGES+1];
	logic signed [CS_W-1:0] y_q [CSTAGES+1];
	logic                   flip_q [CSTAGES+1];
	logic signed [TH_W-1:0] th0;
	logic signed [CS_W-1:0] xf, yf, xr, yr;

	always_comb begin
		th0 = {{(TH_W-ANG_W-16){angle[ANG_W-1]}}, angle, 16'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= CORDIC_K;
			y_q[0] <= '0;
			if (th0 > QUARTER) begin
				th_q[0] <= th0 - HALF;
				flip_q[0] <= 1'b1;
			end else if (th0 < -QUARTER) begin
				th_q[0] <= th0 + HALF;
				flip_q[0] <= 1'b1;
			end else begin
				th_q[0] <= th0;
				flip_q[0] <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < CSTAGES; g++) begin : g_stage
		always_ff @(posedge clk) begin
			logic signed [TH_W-1:0] t;
			logic signed [CS_W-1:0] x, y, nx;
			if (en) begin
				t = th_q[g];
				x = x_q[g];
				y = y_q[g];
				for (int k = 0; k < STEPS_PER_STAGE; k++) begin
					if (t >= 0) begin
						nx = x - (y >>> (g*STEPS_PER_STAGE + k));
						y = y + (x >>> (g*STEPS_PER_STAGE + k));
						t = t - atan_entry(5'(g*STEPS_PER_STAGE + k));
					end else begin
						nx = x + (y >>> (g*STEPS_PER_STAGE + k));
						y = y - (x >>> (g*STEPS_PER_STAGE + k));
						t = t + atan_entry(5'(g*STEPS_PER_STAGE + k));
					end
					x = nx;
				end
				th_q[g+1] <= t;
				x_q[g+1] <= x;
				y_q[g+1] <= y;
				flip_q[g+1] <= flip_q[g];
			end
		end
	end

	always_comb begin
		xf = flip_q[CSTAGES] ? -x_q[CSTAGES] : x_q[CSTAGES];
		yf = flip_q[CSTAGES] ? -y_q[CSTAGES] : y_q[CSTAGES];
		xr = (xf + CS_W'(8192)) >>> 14;
		yr = (yf + CS_W'(8192)) >>> 14;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig.c <= TRIG_W'(xr);
			trig.s <= TRIG_W'(yr);
		end
	end
endmodule
`default_nettype wire

// ===== sv/exr_rot.sv =====
// One plane rotation: products registered, then summed and rounded.
`default_nettype none
module exr_rot (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  exr_pkg::trig_t                       trig,
	input  wire logic signed [exr_pkg::WIDE_W-1:0] a,
	input  wire logic signed [exr_pkg::WIDE_W-1:0] b,
	output logic signed [exr_pkg::WIDE_W-1:0]      oa,
	output logic signed [exr_pkg::WIDE_W-1:0]      ob
);
	import exr_pkg::*;
	localparam int P_W = TRIG_W + WIDE_W;

	logic signed [P_W-1:0] ca_s1, sb_s1, sa_s1, cb_s1;
	logic signed [P_W+1:0] ra, rb;

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s1 <= trig.c * a;
			sb_s1 <= trig.s * b;
			sa_s1 <= trig.s * a;
			cb_s1 <= trig.c * b;
		end
	end

	// oa = c*a - s*b, ob = s*a + c*b (c, s Q1.16), rounded half up.
	always_comb begin
		ra = ((P_W+2)'(ca_s1) - (P_W+2)'(sb_s1) + (P_W+2)'(32768)) >>> 16;
		rb = ((P_W+2)'(sa_s1) + (P_W+2)'(cb_s1) + (P_W+2)'(32768)) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oa <= WIDE_W'(ra);
			ob <= WIDE_W'(rb);
		end
	end
endmodule
`default_nettype wire

// ===== sv/euler_xyz_vector_rotate_unit.sv =====
// Top level of the Euler x-y-z vector rotation pipeline.
// Throughput: one word per cycle when not stalled; three CORDIC pipes run side
// by side and the x, y, z rotations follow in two-stage multiply/round units.
// A stall freezes the whole pipeline; an output register holds the result.
// Reset clears only the valid bits; data registers are not reset.
`default_nettype none
module euler_xyz_vector_rotate_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [exr_pkg::ANG_W-1:0]  angle_x,
	input  wire logic signed [exr_pkg::ANG_W-1:0]  angle_y,
	input  wire logic signed [exr_pkg::ANG_W-1:0]  angle_z,
	input  wire logic signed [exr_pkg::VEC_W-1:0]  vec_x,
	input  wire logic signed [exr_pkg::VEC_W-1:0]  vec_y,
	input  wire logic signed [exr_pkg::VEC_W-1:0]  vec_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [exr_pkg::VEC_W-1:0]       rot_x,
	output logic signed [exr_pkg::VEC_W-1:0]       rot_y,
	output logic signed [exr_pkg::VEC_W-1:0]       rot_z,
	output logic                                   saturated
);
	import exr_pkg::*;
	// sincos: 1 + CSTAGES + 1 = 8; three rotations of 2 each; final clip 1 (out reg).
	localparam int TRIG_LAT = CSTAGES + 2;
	localparam int LAT = TRIG_LAT + 6 + 1;

	logic en;
	logic [LAT-1:0] vld_q;
	trig_t tx, ty, tz;
	trig_t ty_d [2];
	trig_t tz_d [4];
	logic signed [WIDE_W-1:0] vx_d [TRIG_LAT];
	logic signed [WIDE_W-1:0] vy_d [TRIG_LAT];
	logic signed [WIDE_W-1:0] vz_d [TRIG_LAT];
	logic signed [WIDE_W-1:0] x1_d [2];
	logic signed [WIDE_W-1:0] y1, z1, x2, z2, x3, y3;
	logic signed [WIDE_W-1:0] z2_d [2];
	logic signed [WIDE_W-1:0] y1_d [2];
	logic sx, sy, sz;

	assign en = out_ready || !vld_q[LAT-1];
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	exr_sincos u_scx (.clk, .en, .angle(angle_x), .trig(tx));
	exr_sincos u_scy (.clk, .en, .angle(angle_y), .trig(ty));
	exr_sincos u_scz (.clk, .en, .angle(angle_z), .trig(tz));

	always_ff @(posedge clk) begin
		if (en) begin
			vx_d[0] <= WIDE_W'(vec_x);
			vy_d[0] <= WIDE_W'(vec_y);
			vz_d[0] <= WIDE_W'(vec_z);
			for (int i = 1; i < TRIG_LAT; i++) begin
				vx_d[i] <= vx_d[i-1];
				vy_d[i] <= vy_d[i-1];
				vz_d[i] <= vz_d[i-1];
			end
			ty_d[0] <= ty;
			ty_d[1] <= ty_d[0];
			tz_d[0] <= tz;
			for (int i = 1; i < 4; i++) tz_d[i] <= tz_d[i-1];
			x1_d[0] <= vx_d[TRIG_LAT-1];
			x1_d[1] <= x1_d[0];
			z2_d[0] <= z2;
			z2_d[1] <= z2_d[0];
		end
	end

	// About x: y' = c*y - s*z, z' = s*y + c*z.
	exr_rot u_rx (.clk, .en, .trig(tx), .a(vy_d[TRIG_LAT-1]), .b(vz_d[TRIG_LAT-1]),
		.oa(y1), .ob(z1));
	// About y: x' = c*x + s*z, z' = -s*x + c*z, done as a rotation of (z, x).
	exr_rot u_ry (.clk, .en, .trig(ty_d[1]), .a(z1), .b(x1_d[1]), .oa(z2), .ob(x2));
	// About z: x' = c*x - s*y, y' = s*x + c*y.
	always_ff @(posedge clk) begin
		if (en) begin
			y1_d[0] <= y1;
			y1_d[1] <= y1_d[0];
		end
	end
	exr_rot u_rz (.clk, .en, .trig(tz_d[3]), .a(x2), .b(y1_d[1]), .oa(x3), .ob(y3));

	always_comb begin
		sx = (x3 > OUT_MAX) || (x3 < OUT_MIN);
		sy = (y3 > OUT_MAX) || (y3 < OUT_MIN);
		sz = (z2_d[1] > OUT_MAX) || (z2_d[1] < OUT_MIN);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_x <= (x3 > OUT_MAX) ? VEC_W'(OUT_MAX) :
				(x3 < OUT_MIN) ? VEC_W'(OUT_MIN) : VEC_W'(x3);
			rot_y <= (y3 > OUT_MAX) ? VEC_W'(OUT_MAX) :
				(y3 < OUT_MIN) ? VEC_W'(OUT_MIN) : VEC_W'(y3);
			rot_z <= (z2_d[1] > OUT_MAX) ? VEC_W'(OUT_MAX) :
				(z2_d[1] < OUT_MIN) ? VEC_W'(OUT_MIN) : VEC_W'(z2_d[1]);
			saturated <= sx | sy | sz;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(saturated))
		else $error("output word changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipeline stalled with an empty output register");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> !vld_q[0])
		else $error("valid bit appeared without an accepted word");
endmodule
`default_nettype wire
